### rtl/core/cle_pkg.sv
`timescale 1ns / 1ps
// cle_pkg: shared types and key codes for the cursor line editor
// no dependencies; imported by cle_cell, cle_stack and cursor_line_editor

package cle_pkg;

    // one character of text
    typedef logic [7:0] t_char;

    // stack operation handed from the controller to a stack and its cells
    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_op;

    // special key codes
    localparam t_char KEY_LEFT  = 8'h3C;
    localparam t_char KEY_RIGHT = 8'h3E;
    localparam t_char KEY_DEL   = 8'h2D;
    localparam t_char KEY_NL    = 8'h0A;
    localparam t_char KEY_NUL   = 8'h00;

    // opcode values
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_READ = 1'b1;

endpackage

### rtl/core/cle_cell.sv
`timescale 1ns / 1ps
// cle_cell: one character slot of a stack chain
// depends on cle_pkg; instantiated by cle_stack

module cle_cell (
    input  logic               i_clk,
    input  cle_pkg::t_stack_op i_op,
    input  cle_pkg::t_char     i_from_above,
    input  cle_pkg::t_char     i_from_below,
    output cle_pkg::t_char     o_data
);
    import cle_pkg::*;

    t_char r_data;
    t_char n_data;

    // push shifts down from the neighbor above, pop shifts up from below
    always_comb begin
        priority if (i_op.push) begin
            n_data = i_from_above;
        end else if (i_op.pop) begin
            n_data = i_from_below;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

### rtl/core/cle_stack.sv
`timescale 1ns / 1ps
// cle_stack: a chain of cle_cell slots with a fill count, cell 0 is the top
// depends on cle_pkg and cle_cell; instantiated by cursor_line_editor

module cle_stack #(
    parameter int DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cle_pkg::t_stack_op            i_op,
    input  cle_pkg::t_char                i_push_data,
    output cle_pkg::t_char                o_top,
    output logic [$clog2(DEPTH+1)-1:0]    o_count
);
    import cle_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    t_char          w_data [DEPTH];
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;

    // row of cells, each fed by its two neighbors
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_char w_above;
        t_char w_below;
        if (g == 0) begin : g_top
            assign w_above = i_push_data;
        end else begin : g_mid
            assign w_above = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_bot
            assign w_below = '0;
        end else begin : g_up
            assign w_below = w_data[g+1];
        end
        cle_cell u_cell (
            .i_clk        (i_clk),
            .i_op         (i_op),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .o_data       (w_data[g])
        );
    end

    // fill count
    always_comb begin
        priority if (i_op.push) begin
            n_count = r_count + CW'(1);
        end else if (i_op.pop) begin
            n_count = r_count - CW'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_top   = w_data[0];
    assign o_count = r_count;

endmodule

### rtl/core/cursor_line_editor.sv
`timescale 1ns / 1ps
// cursor_line_editor: keystroke line editor with a cursor, two cell-chain stacks
// depends on cle_pkg and cle_stack
//
// Usage
//   Input channel (i_in_valid / o_in_stall) carries one word: i_opcode and
//   i_key_code. A key word ('<', '>', '-', ignored codes, or an insert) is
//   applied in the cycle it is accepted and yields no output word; the next
//   word can follow in the following cycle.
//   A readout word first shifts the text left of the cursor onto the right
//   stack, one character per cycle, then emits the line on the output channel
//   (o_out_valid / i_out_stall), one character per cycle while the output is
//   not stalled, last flagged by o_last. An empty line gives a single word
//   with o_char_valid low. o_in_stall is high throughout the readout, while
//   the merge walk moves each character left of the cursor and the emit walk
//   gives each character of the line (or the single empty-line word).
//   The output register holds its word while i_out_stall is high, and the
//   emit walk waits with it; key words are taken while a final word waits.
//   Reset (synchronous, active low) empties the line and clears the pending
//   overflow flags; the o_overflow register and character storage are not reset.

module cursor_line_editor #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_opcode,
    input  logic [7:0] i_key_code,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_text_char,
    output logic       o_char_valid,
    output logic       o_last,
    output logic       o_overflow
);
    import cle_pkg::*;

    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MERGE = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic          r_ovf;
    logic          n_ovf;
    logic          r_run_ovf;
    logic          n_run_ovf;
    logic          r_out_valid;
    logic          n_out_valid;
    t_char         r_text_char;
    t_char         n_text_char;
    logic          r_char_valid;
    logic          n_char_valid;
    logic          r_last;
    logic          n_last;

    t_stack_op     w_left_op;
    t_stack_op     w_right_op;
    t_char         w_left_push;
    t_char         w_right_push;
    t_char         w_left_top;
    t_char         w_right_top;
    logic [CW-1:0] w_left_count;
    logic [CW-1:0] w_right_count;
    logic [CW:0]   w_used;
    logic          w_accept;
    logic          w_out_free;
    t_char         w_key;

    // left of cursor, top is the character just before the cursor
    cle_stack #(.DEPTH(BUFFER_DEPTH)) u_left (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_left_op),
        .i_push_data (w_left_push),
        .o_top       (w_left_top),
        .o_count     (w_left_count)
    );

    // right of cursor, top is the character just after the cursor
    cle_stack #(.DEPTH(BUFFER_DEPTH)) u_right (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_right_op),
        .i_push_data (w_right_push),
        .o_top       (w_right_top),
        .o_count     (w_right_count)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_used     = {1'b0, w_left_count} + {1'b0, w_right_count};
    assign w_key      = i_key_code;

    // controller: key edits, merge walk and emit walk
    always_comb begin
        n_state      = r_state;
        n_ovf        = r_ovf;
        n_run_ovf    = r_run_ovf;
        n_out_valid  = r_out_valid && i_out_stall;
        n_text_char  = r_text_char;
        n_char_valid = r_char_valid;
        n_last       = r_last;
        w_left_op    = '0;
        w_right_op   = '0;
        w_left_push  = w_key;
        w_right_push = w_left_top;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_opcode == OP_READ) begin
                        n_run_ovf = r_ovf;
                        n_ovf     = 1'b0;
                        n_state   = (w_left_count != '0) ? ST_MERGE : ST_EMIT;
                    end else begin
                        priority if (w_key == KEY_LEFT) begin
                            if (w_left_count != '0) begin
                                w_left_op.pop   = 1'b1;
                                w_right_op.push = 1'b1;
                                w_right_push    = w_left_top;
                            end
                        end else if (w_key == KEY_RIGHT) begin
                            if (w_right_count != '0) begin
                                w_right_op.pop = 1'b1;
                                w_left_op.push = 1'b1;
                                w_left_push    = w_right_top;
                            end
                        end else if (w_key == KEY_DEL) begin
                            if (w_left_count != '0) begin
                                w_left_op.pop = 1'b1;
                            end
                        end else if (w_key == KEY_NUL || w_key == KEY_NL) begin
                            // ignored codes
                        end else begin
                            if (w_used < (CW+1)'(BUFFER_DEPTH)) begin
                                w_left_op.push = 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_MERGE: begin
                // move one character from the left stack to the right stack
                w_left_op.pop   = 1'b1;
                w_right_op.push = 1'b1;
                w_right_push    = w_left_top;
                if (w_left_count == CW'(1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (w_right_count == '0) begin
                        // empty line gives a single marker word
                        n_text_char  = '0;
                        n_char_valid = 1'b0;
                        n_last       = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        w_right_op.pop = 1'b1;
                        n_text_char    = w_right_top;
                        n_char_valid   = 1'b1;
                        n_last         = (w_right_count == CW'(1));
                        if (w_right_count == CW'(1)) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ovf       <= 1'b0;
            r_run_ovf   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ovf       <= n_ovf;
            r_run_ovf   <= n_run_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        r_text_char  <= n_text_char;
        r_char_valid <= n_char_valid;
        r_last       <= n_last;
    end

    // flag taken at readout start, loaded with every emitted word of the run
    logic r_out_ovf;
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && w_out_free) begin
            r_out_ovf <= r_run_ovf;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_text_char  = r_text_char;
    assign o_char_valid = r_char_valid;
    assign o_last       = r_last;
    assign o_overflow   = r_out_ovf;

endmodule
